@@ design/mpkt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpkt_pkg
// Shared widths, constants and types for the k-transaction profit core.
// ----------------------------------------------------------------------------
package mpkt_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 32;
  localparam int HOLD_W   = 34;
  localparam int CFG_W    = 5;

  localparam int MAX_TRANSACTIONS_DEF = 16;

  localparam logic [CFG_W-1:0]    CFG_RESET  = 5'd2;
  localparam logic [HOLD_W-1:0]   HOLD_NONE  = {1'b1, {(HOLD_W-1){1'b0}}};
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  typedef struct packed {
    logic upd;
    logic first;
  } cell_ctrl_t;

endpackage

@@ design/mpkt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpkt_cell
// One transaction-count cell: best cash holding a share and best free cash,
// updated from the left neighbor's free cash on every accepted price.
// ----------------------------------------------------------------------------
module mpkt_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  mpkt_pkg::cell_ctrl_t               ctrl,
  input  logic [mpkt_pkg::PRICE_W-1:0]       price,
  input  logic [mpkt_pkg::PROFIT_W-1:0]      free_in,
  output logic [mpkt_pkg::PROFIT_W-1:0]      free_out
);

  logic signed [mpkt_pkg::HOLD_W-1:0] hold;
  logic signed [mpkt_pkg::HOLD_W-1:0] hold_next;
  logic        [mpkt_pkg::PROFIT_W-1:0] free;
  logic        [mpkt_pkg::PROFIT_W-1:0] free_next;

  logic signed [mpkt_pkg::HOLD_W-1:0] hold_old;
  logic signed [mpkt_pkg::HOLD_W-1:0] free_old_s;
  logic signed [mpkt_pkg::HOLD_W-1:0] prev_old_s;
  logic signed [mpkt_pkg::HOLD_W-1:0] price_s;
  logic signed [mpkt_pkg::HOLD_W-1:0] buy;
  logic signed [mpkt_pkg::HOLD_W-1:0] sell;
  logic signed [mpkt_pkg::HOLD_W-1:0] max_s;

  // first clears the stored values before this price is used
  always_comb begin
    hold_old   = ctrl.first ? $signed(mpkt_pkg::HOLD_NONE) : hold;
    free_old_s = ctrl.first ? '0
                 : $signed({{(mpkt_pkg::HOLD_W-mpkt_pkg::PROFIT_W){1'b0}}, free});
    prev_old_s = ctrl.first ? '0
                 : $signed({{(mpkt_pkg::HOLD_W-mpkt_pkg::PROFIT_W){1'b0}}, free_in});
    price_s    = $signed({{(mpkt_pkg::HOLD_W-mpkt_pkg::PRICE_W){1'b0}}, price});
    max_s      = $signed({{(mpkt_pkg::HOLD_W-mpkt_pkg::PROFIT_W){1'b0}},
                          mpkt_pkg::PROFIT_MAX});
    buy        = prev_old_s - price_s;
    sell       = hold_old + price_s;
    hold_next  = (buy > hold_old) ? buy : hold_old;
    if (sell > free_old_s) begin
      free_next = (sell > max_s) ? mpkt_pkg::PROFIT_MAX : sell[mpkt_pkg::PROFIT_W-1:0];
    end else begin
      free_next = free_old_s[mpkt_pkg::PROFIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= $signed(mpkt_pkg::HOLD_NONE);
      free <= '0;
    end else if (ctrl.upd) begin
      hold <= hold_next;
      free <= free_next;
    end
  end

  assign free_out = free;

endmodule

@@ design/max_profit_k_transactions_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_transactions_core
// Best profit from at most k buy-then-sell transactions over a price stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with price and first. A transfer with
// first set starts a new sequence. Every input transfer gives exactly one
// result on the output channel: out_valid / out_stall with best_profit.
// Configuration: cfg_we writes cfg_wdata into the transaction limit; write
// it only while the core is idle. Limits above MAX_TRANSACTIONS saturate.
// A row of MAX_TRANSACTIONS cells, one per transaction count, updates in
// parallel at each input transfer; once the output register is free, the
// selected cell's free cash moves into that output register.
// The cells register the input transfer, then the output register takes the
// result and raises out_valid. Throughput: one price per cycle while the
// output is taken.
// Receiver stall: one finished result waits in the output register and one
// more in the cells; after that in_stall rises until the output moves.
// Reset: cells clear to an empty sequence, the limit returns to 2, no result
// is pending.
// ----------------------------------------------------------------------------
module max_profit_k_transactions_core #(
  parameter int MAX_TRANSACTIONS = mpkt_pkg::MAX_TRANSACTIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mpkt_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mpkt_pkg::PRICE_W-1:0]       price,
  input  logic                               first,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mpkt_pkg::PROFIT_W-1:0]      best_profit
);

  localparam int KW   = $clog2(MAX_TRANSACTIONS + 1);
  localparam int CMPW = (KW > mpkt_pkg::CFG_W) ? KW : mpkt_pkg::CFG_W;

  logic [mpkt_pkg::CFG_W-1:0]    max_transactions;
  logic                          pend;
  logic                          pend_next;
  logic                          out_valid_next;
  logic                          load_out;
  logic                          in_xfer;
  logic [KW-1:0]                 k_sel;
  logic [CMPW-1:0]               cfg_ext;
  logic [mpkt_pkg::PROFIT_W-1:0] free_tap [0:MAX_TRANSACTIONS];
  mpkt_pkg::cell_ctrl_t          ctrl;

  assign load_out = pend && (!out_valid || !out_stall);
  assign in_stall = pend && out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign ctrl.upd   = in_xfer;
  assign ctrl.first = first;

  assign free_tap[0] = '0;

  genvar j;
  generate
    for (j = 1; j <= MAX_TRANSACTIONS; j++) begin : g_cell
      mpkt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .price    (price),
        .free_in  (free_tap[j-1]),
        .free_out (free_tap[j])
      );
    end
  endgenerate

  always_comb begin
    cfg_ext = CMPW'(max_transactions);
    if (cfg_ext > CMPW'(MAX_TRANSACTIONS)) begin
      k_sel = KW'(MAX_TRANSACTIONS);
    end else begin
      k_sel = KW'(max_transactions);
    end
  end

  always_comb begin
    pend_next      = in_xfer || (pend && !load_out);
    out_valid_next = load_out || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_transactions <= mpkt_pkg::CFG_RESET;
      pend             <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_transactions <= cfg_wdata;
      end
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      best_profit <= free_tap[k_sel];
    end
  end

endmodule

@@ design/mpkt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpkt_checker
// Port-level checks on the k-transaction profit core, bound to the top level.
// ----------------------------------------------------------------------------
module mpkt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mpkt_pkg::PROFIT_W-1:0] best_profit
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_profit))
    else $error("stalled result changed");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching input transfer");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind max_profit_k_transactions_core mpkt_checker u_mpkt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .best_profit (best_profit)
);

@@ tb/max_profit_k_transactions_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_transactions_core_tb
// Self-checking bench for the k-transaction stock profit core.
// ----------------------------------------------------------------------------
// A per-transfer profit model runs alongside the core. Each accepted price
// updates the model's hold/free cash rows, and the best profit for the
// current transaction limit is queued. Every result transfer is checked
// against the oldest queued profit. Directed cases cover the reset limit,
// a zero limit, full price swings, limits beyond the cell count and a limit
// change in the middle of a sequence. Random price series then run under
// several sender idle and receiver stall mixes, with limit rewrites while
// the core is drained.
// ----------------------------------------------------------------------------
module max_profit_k_transactions_core_tb;

  localparam int CELLS = mpkt_pkg::MAX_TRANSACTIONS_DEF;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [mpkt_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [mpkt_pkg::PRICE_W-1:0]  price = '0;
  logic                          first = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [mpkt_pkg::PROFIT_W-1:0] best_profit;

  logic signed [mpkt_pkg::HOLD_W-1:0] hold_cash [1:CELLS];
  logic [mpkt_pkg::PROFIT_W:0]        free_cash [0:CELLS];
  logic [mpkt_pkg::CFG_W-1:0]         txn_limit = mpkt_pkg::CFG_RESET;
  logic [mpkt_pkg::PROFIT_W-1:0]      expected_profit_q [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int n_prices = 0;
  int n_results = 0;
  int n_limit_writes = 0;
  int n_errors = 0;
  logic [mpkt_pkg::PRICE_W-1:0] walk_price = 16'd1000;

  max_profit_k_transactions_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .price       (price),
    .first       (first),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .best_profit (best_profit)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
  end

  task automatic clear_cash_rows();
    for (int j = 0; j <= CELLS; j++) begin
      free_cash[j] = '0;
      if (j > 0) hold_cash[j] = mpkt_pkg::HOLD_NONE;
    end
  endtask

  task automatic predict_profit(input logic [mpkt_pkg::PRICE_W-1:0] p, input logic f);
    logic signed [mpkt_pkg::HOLD_W-1:0] prev_hold [1:CELLS];
    logic [mpkt_pkg::PROFIT_W:0]        prev_free [0:CELLS];
    longint buy;
    longint sell;
    longint old_hold;
    longint old_free;
    int k;
    if (f) clear_cash_rows();
    prev_hold = hold_cash;
    prev_free = free_cash;
    for (int j = 1; j <= CELLS; j++) begin
      old_hold = longint'(prev_hold[j]);
      old_free = longint'({31'd0, prev_free[j]});
      buy = longint'({31'd0, prev_free[j-1]}) - longint'({48'd0, p});
      sell = old_hold + longint'({48'd0, p});
      if (sell > longint'({32'd0, mpkt_pkg::PROFIT_MAX})) begin
        sell = longint'({32'd0, mpkt_pkg::PROFIT_MAX});
      end
      hold_cash[j] = (buy > old_hold) ? buy[mpkt_pkg::HOLD_W-1:0]
                                      : old_hold[mpkt_pkg::HOLD_W-1:0];
      free_cash[j] = (sell > old_free) ? sell[mpkt_pkg::PROFIT_W:0]
                                       : old_free[mpkt_pkg::PROFIT_W:0];
    end
    free_cash[0] = '0;
    k = (int'(txn_limit) > CELLS) ? CELLS : int'(txn_limit);
    expected_profit_q = {expected_profit_q, free_cash[k][mpkt_pkg::PROFIT_W-1:0]};
  endtask

  // one price transfer, with random sender gaps ahead of it
  task automatic send_price(input logic [mpkt_pkg::PRICE_W-1:0] p, input logic f);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    price    <= p;
    first    <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_profit(p, f);
    n_prices++;
  endtask

  task automatic drain_core();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_profit_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [mpkt_pkg::CFG_W-1:0] value);
    drain_core();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    txn_limit = value;
    n_limit_writes++;
  endtask

  function automatic logic [mpkt_pkg::PRICE_W-1:0] next_price();
    int delta;
    case ($urandom_range(0, 9))
      0: walk_price = '0;
      1: walk_price = '1;
      2, 3: begin
        delta = $urandom;
        walk_price = delta[mpkt_pkg::PRICE_W-1:0];
      end
      default: begin
        delta = $urandom_range(0, 600) - 300;
        walk_price = walk_price + delta[mpkt_pkg::PRICE_W-1:0];
      end
    endcase
    return walk_price;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_profit_q.size() == 0) begin
        $display("%0t: best_profit with nothing expected, actual %0d", $time, best_profit);
        n_errors++;
      end else begin
        if (best_profit !== expected_profit_q[0]) begin
          $display("%0t: best_profit expected %0d actual %0d",
                   $time, expected_profit_q[0], best_profit);
          n_errors++;
        end
        void'(expected_profit_q.pop_front());
      end
    end
  end

  // reset limit, no first flag: reset state is an empty sequence
  task automatic test_reset_limit();
    send_price(16'd10, 1'b0);
    send_price(16'd5, 1'b0);
    send_price(16'd20, 1'b0);
    send_price(16'd3, 1'b0);
    send_price(16'd30, 1'b0);
  endtask

  task automatic test_zero_limit();
    write_limit(5'd0);
    send_price(16'd0, 1'b1);
    send_price(16'hFFFF, 1'b0);
    send_price(16'd7, 1'b0);
  endtask

  task automatic test_full_swing();
    write_limit(5'd16);
    for (int i = 0; i < 8; i++) send_price(i[0] ? 16'hFFFF : 16'h0000, i == 0);
  endtask

  task automatic test_limit_above_cells();
    write_limit(5'd31);
    send_price(16'h0000, 1'b0);
    send_price(16'hFFFF, 1'b0);
    write_limit(5'd17);
    send_price(16'h5555, 1'b0);
    send_price(16'hAAAA, 1'b0);
  endtask

  task automatic test_limit_change_midseq();
    write_limit(5'd1);
    send_price(16'd100, 1'b1);
    send_price(16'd300, 1'b0);
    send_price(16'd50, 1'b0);
    write_limit(5'd5);
    send_price(16'd400, 1'b0);
    send_price(16'd10, 1'b0);
  endtask

  task automatic test_random_series(input int n_items, input int idle, input int stall);
    int sent;
    int seq_len;
    int pick;
    logic [mpkt_pkg::CFG_W-1:0] lim;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0: lim = 5'd0;
          1: lim = 5'd1;
          2: lim = 5'd16;
          3: lim = 5'd31;
          default: begin
            pick = $urandom_range(0, 31);
            lim = pick[mpkt_pkg::CFG_W-1:0];
          end
        endcase
        write_limit(lim);
      end
      seq_len = $urandom_range(1, 48);
      for (int i = 0; i < seq_len && sent < n_items; i++) begin
        send_price(next_price(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                         : ($urandom_range(0, 39) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    clear_cash_rows();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_limit();
    test_zero_limit();
    test_full_swing();
    test_limit_above_cells();
    test_limit_change_midseq();
    test_random_series(400, 0, 0);
    test_random_series(400, 57, 0);
    test_random_series(400, 0, 57);
    test_random_series(400, 38, 38);
    drain_core();
    $display("checked %0d price transfers and %0d results over %0d limit writes",
             n_prices, n_results, n_limit_writes);
    $display("idle/stall mixes: none, sender 57%%, receiver 57%%, both 38%%");
    if (n_errors == 0 && expected_profit_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_profit_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
design/mpkt_pkg.sv
design/mpkt_cell.sv
design/max_profit_k_transactions_core.sv
design/mpkt_checker.sv
tb/max_profit_k_transactions_core_tb.sv
